// ===== sv/bfpu_pkg.sv =====
// ----------------------------------------------------------------------------
// bfpu_pkg
// shared types, field widths and command codes of the bit-field packer
// ----------------------------------------------------------------------------
package bfpu_pkg;

	localparam int CMD_W    = 2;
	localparam int VALUE_W  = 64;
	localparam int LEN_W    = 7;
	localparam int CURSOR_W = 12;
	localparam int CFG_W    = 9;
	// alignment window: one field plus the bit offset into its first byte
	localparam int WIN_W    = VALUE_W + 8;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [VALUE_W-1:0]  value_t;
	typedef logic [LEN_W-1:0]    len_t;
	typedef logic [CURSOR_W-1:0] cursor_t;
	typedef logic [CFG_W-1:0]    cfg_t;

	localparam cmd_t CMD_APPEND  = 2'd0;
	localparam cmd_t CMD_EXTRACT = 2'd1;
	localparam cmd_t CMD_CLEAR   = 2'd2;

	localparam cfg_t CFG_RESET = 9'd256;

	// ones in the low len bits, all ones for a full-width field
	function automatic value_t field_mask(len_t len);
		value_t ones;
		ones = '1;
		return ~(ones << len);
	endfunction

endpackage

// ===== sv/bfpu_if.sv =====
// ----------------------------------------------------------------------------
// bfpu request and response channels
// valid/ready channels carrying one command item and one result item
// ----------------------------------------------------------------------------
interface bfpu_req_if;
	logic            valid;
	logic            ready;
	bfpu_pkg::cmd_t   cmd;
	bfpu_pkg::value_t field_value;
	bfpu_pkg::len_t   field_length;

	modport source(output valid, cmd, field_value, field_length, input ready);
	modport sink(input valid, cmd, field_value, field_length, output ready);
endinterface

interface bfpu_rsp_if;
	logic              valid;
	logic              ready;
	logic              status;
	bfpu_pkg::value_t  read_value;
	bfpu_pkg::cursor_t write_cursor;
	bfpu_pkg::cursor_t read_cursor;

	modport source(output valid, status, read_value, write_cursor, read_cursor,
		input ready);
	modport sink(input valid, status, read_value, write_cursor, read_cursor,
		output ready);
endinterface

// ===== sv/bit_field_pack_unpack_buffer_top.sv =====
// ----------------------------------------------------------------------------
// bit_field_pack_unpack_buffer_top
// bit-addressed byte store with msb-first append and extract cursors
// ----------------------------------------------------------------------------
// usage:
//   req carries one command item (append, extract, clear); rsp returns one
//   result item per command with status, extracted bits and both cursors
//   cfg_we/cfg_wdata set the number of usable store bytes, written while idle
// sequencing (one item in flight, ready only in the idle state):
//   accept, a setup step, then each store byte touched, one at a time through
//   the single memory port (up to nine for a 64-bit field), then a load of
//   the result register; extract adds a wait for the registered memory read
//   and a finish step to align the result; clear or reject go from setup
//   straight to the result state
//   the next item is accepted the cycle after the result is loaded
// reset:
//   cursors go to zero, usable size to 256; the store needs no sweep: bytes
//   at or beyond the write fill point always read as zero, so clear only
//   resets the cursors
// stall:
//   a waiting result sits in the output register while the next item is
//   taken and worked; that item holds in its result state until rsp frees
// ----------------------------------------------------------------------------
module bit_field_pack_unpack_buffer_top #(
	parameter int BUFFER_BYTES   = 256,
	parameter int MAX_FIELD_BITS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [bfpu_pkg::CFG_W-1:0] cfg_wdata,
	bfpu_req_if.sink               req,
	bfpu_rsp_if.source             rsp
);

	localparam int AW     = $clog2(BUFFER_BYTES);
	localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
	localparam int POS_W  = $clog2(BUFFER_BYTES * 8 + 1);
	localparam int SUM_W  = $clog2(BUFFER_BYTES * 8 + 128);
	localparam int WIDE_W = ((SUM_W > bfpu_pkg::CFG_W) ? SUM_W : bfpu_pkg::CFG_W) + 1;
	localparam int WIN_W  = bfpu_pkg::WIN_W;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SETUP   = 3'd1;
	localparam logic [2:0] ST_APPEND  = 3'd2;
	localparam logic [2:0] ST_EXTRACT = 3'd3;
	localparam logic [2:0] ST_FINISH  = 3'd4;
	localparam logic [2:0] ST_RESULT  = 3'd5;

	// control state
	logic [2:0]       st_q;
	logic [POS_W-1:0] wp_q;
	logic [POS_W-1:0] rp_q;
	bfpu_pkg::cfg_t   cfg_q;
	logic             ov_q;
	logic             rd_pend_s1;

	// item and datapath registers
	bfpu_pkg::cmd_t    cmd_q;
	bfpu_pkg::value_t  val_q;
	bfpu_pkg::len_t    len_q;
	logic [WIN_W-1:0]  win_q;
	logic [WIN_W-1:0]  acc_q;
	logic [AW-1:0]     addr_q;
	logic [3:0]        iss_q;
	logic [3:0]        rcv_q;
	logic [2:0]        pad_q;
	logic              part_q;
	logic              first_q;
	logic              rd_live_s1;
	logic              res_status_q;
	bfpu_pkg::value_t  res_value_q;
	logic              out_status_q;
	bfpu_pkg::value_t  out_value_q;
	bfpu_pkg::cursor_t out_wcur_q;
	bfpu_pkg::cursor_t out_rcur_q;

	// byte store, one read or write port in use per cycle
	logic [7:0] store_mem [BUFFER_BYTES];
	logic [7:0] rd_data_q;

	logic [2:0]        bitoff;
	logic [7:0]        span;
	logic [3:0]        nbytes;
	logic [2:0]        pad;
	logic [6:0]        win_sh;
	logic [WIN_W-1:0]  win_new;
	logic [WIDE_W-1:0] limit_bytes;
	logic [SUM_W-1:0]  limit_bits;
	logic [SUM_W-1:0]  wr_end;
	logic [SUM_W-1:0]  rd_end;
	logic              len_ok;
	logic              app_ok;
	logic              ext_ok;
	logic [AW-1:0]     wp_idx;
	logic [AW-1:0]     rp_idx;
	logic [FILL_W-1:0] fill;
	logic              mem_re;
	logic [AW-1:0]     mem_rd_addr;
	logic              mem_we;
	logic [7:0]        wr_byte;
	logic              out_free;

	// field geometry: bit offset into the first byte and bytes spanned
	always_comb begin
		bitoff  = (cmd_q == bfpu_pkg::CMD_EXTRACT) ? rp_q[2:0] : wp_q[2:0];
		span    = 8'(bitoff) + 8'(len_q);
		nbytes  = 4'((span + 8'd7) >> 3);
		pad     = 3'(8'd0 - span);
		win_sh  = 7'(8'(WIN_W) - span);
		win_new = WIN_W'(val_q & bfpu_pkg::field_mask(len_q)) << win_sh;
	end

	// bounds: usable size clipped to the store, checked in bits
	always_comb begin
		limit_bytes = (WIDE_W'(cfg_q) > WIDE_W'(BUFFER_BYTES)) ?
			WIDE_W'(BUFFER_BYTES) : WIDE_W'(cfg_q);
		limit_bits  = SUM_W'({limit_bytes, 3'b000});
		wr_end      = SUM_W'(wp_q) + SUM_W'(len_q);
		rd_end      = SUM_W'(rp_q) + SUM_W'(len_q);
		len_ok      = (len_q <= bfpu_pkg::LEN_W'(MAX_FIELD_BITS));
		app_ok      = len_ok && (wr_end <= limit_bits);
		ext_ok      = (len_q != '0) && len_ok && (rd_end <= limit_bits);
		wp_idx      = AW'(wp_q >> 3);
		rp_idx      = AW'(rp_q >> 3);
		// bytes below the fill point hold appended data, the rest read as zero
		fill        = FILL_W'((SUM_W'(wp_q) + SUM_W'(7)) >> 3);
	end

	// memory port control
	always_comb begin
		mem_re      = 1'b0;
		mem_rd_addr = addr_q;
		if (st_q == ST_SETUP && cmd_q == bfpu_pkg::CMD_APPEND) begin
			// partial first byte of an append is merged with what is stored
			mem_re      = 1'b1;
			mem_rd_addr = wp_idx;
		end else if (st_q == ST_EXTRACT && iss_q != '0) begin
			mem_re = 1'b1;
		end
		mem_we  = (st_q == ST_APPEND);
		wr_byte = win_q[WIN_W-1 -: 8] | ((first_q && part_q) ? rd_data_q : 8'h00);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[addr_q] <= wr_byte;
		end
		if (mem_re) begin
			rd_data_q <= store_mem[mem_rd_addr];
		end
	end

	assign out_free = !ov_q || rsp.ready;

	// sequencer and cursors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			wp_q       <= '0;
			rp_q       <= '0;
			cfg_q      <= bfpu_pkg::CFG_RESET;
			ov_q       <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			rd_pend_s1 <= (st_q == ST_EXTRACT) && (iss_q != '0);
			// output register: loaded from the result state, freed by rsp
			if (st_q == ST_RESULT && out_free) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (req.valid) begin
						st_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					unique case (cmd_q)
						bfpu_pkg::CMD_APPEND: begin
							st_q <= (app_ok && nbytes != '0) ? ST_APPEND : ST_RESULT;
						end
						bfpu_pkg::CMD_EXTRACT: begin
							st_q <= ext_ok ? ST_EXTRACT : ST_RESULT;
						end
						bfpu_pkg::CMD_CLEAR: begin
							wp_q <= '0;
							rp_q <= '0;
							st_q <= ST_RESULT;
						end
						default: begin
							st_q <= ST_RESULT;
						end
					endcase
				end
				ST_APPEND: begin
					if (iss_q == 4'd1) begin
						wp_q <= POS_W'(wr_end);
						st_q <= ST_RESULT;
					end
				end
				ST_EXTRACT: begin
					if (rd_pend_s1 && rcv_q == 4'd1) begin
						st_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					rp_q <= POS_W'(rd_end);
					st_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item datapath: byte stepping, extract assembly and result registers
	always_ff @(posedge clk) begin
		rd_live_s1 <= (FILL_W'(addr_q) < fill);
		case (st_q)
			ST_IDLE: begin
				cmd_q <= req.cmd;
				val_q <= req.field_value;
				len_q <= req.field_length;
			end
			ST_SETUP: begin
				res_value_q <= '0;
				case (cmd_q)
					bfpu_pkg::CMD_APPEND: begin
						res_status_q <= !app_ok;
						win_q        <= win_new;
						addr_q       <= wp_idx;
						iss_q        <= nbytes;
						part_q       <= (wp_q[2:0] != 3'd0);
						first_q      <= 1'b1;
					end
					bfpu_pkg::CMD_EXTRACT: begin
						res_status_q <= !ext_ok;
						addr_q       <= rp_idx;
						iss_q        <= nbytes;
						rcv_q        <= nbytes;
						pad_q        <= pad;
						acc_q        <= '0;
					end
					bfpu_pkg::CMD_CLEAR: begin
						res_status_q <= 1'b0;
					end
					default: begin
						res_status_q <= 1'b1;
					end
				endcase
			end
			ST_APPEND: begin
				addr_q  <= addr_q + AW'(1);
				win_q   <= win_q << 8;
				iss_q   <= iss_q - 4'd1;
				first_q <= 1'b0;
			end
			ST_EXTRACT: begin
				if (iss_q != '0) begin
					addr_q <= addr_q + AW'(1);
					iss_q  <= iss_q - 4'd1;
				end
				if (rd_pend_s1) begin
					acc_q <= {acc_q[WIN_W-9:0], rd_live_s1 ? rd_data_q : 8'h00};
					rcv_q <= rcv_q - 4'd1;
				end
			end
			ST_FINISH: begin
				// drop the bits after the field's last bit, keep len bits
				res_value_q <= bfpu_pkg::VALUE_W'(acc_q >> pad_q) &
					bfpu_pkg::field_mask(len_q);
			end
			ST_RESULT: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_value_q  <= res_value_q;
					out_wcur_q   <= bfpu_pkg::CURSOR_W'(wp_q);
					out_rcur_q   <= bfpu_pkg::CURSOR_W'(rp_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready        = (st_q == ST_IDLE);
	assign rsp.valid        = ov_q;
	assign rsp.status       = out_status_q;
	assign rsp.read_value   = out_value_q;
	assign rsp.write_cursor = out_wcur_q;
	assign rsp.read_cursor  = out_rcur_q;

endmodule

// ===== sv/bfpu_checker.sv =====
// ----------------------------------------------------------------------------
// bfpu_checker
// port-level checks on the packer's request and response channels
// ----------------------------------------------------------------------------
module bfpu_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic                      rsp_status,
	input logic [bfpu_pkg::VALUE_W-1:0]  rsp_read_value,
	input logic [bfpu_pkg::CURSOR_W-1:0] rsp_write_cursor,
	input logic [bfpu_pkg::CURSOR_W-1:0] rsp_read_cursor
);

	logic       req_fire;
	logic       rsp_fire;
	logic [1:0] outst_q;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// items accepted and not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else begin
			outst_q <= outst_q + 2'(req_fire) - 2'(rsp_fire);
		end
	end

	// no result without an item behind it
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> outst_q != 2'd0)
		else $error("result shown with no item outstanding");

	// one item in work plus one waiting result at most
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q <= 2'd2)
		else $error("more than two items outstanding");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req_ready)
		else $error("request taken again right after an accept");

	// a rejected command returns no bits
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> rsp_read_value == '0)
		else $error("rejected item with nonzero read value");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
		$stable(rsp_read_value) && $stable(rsp_write_cursor) &&
		$stable(rsp_read_cursor))
		else $error("stalled result changed");

endmodule

bind bit_field_pack_unpack_buffer_top bfpu_checker u_bfpu_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_read_value   (rsp.read_value),
	.rsp_write_cursor (rsp.write_cursor),
	.rsp_read_cursor  (rsp.read_cursor)
);
